@@ rtl/rotation_matrix_to_axis_angle_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to axis-angle core
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_AXIS_ANGLE_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_AXIS_ANGLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define RM2AA_ASSERT(name, clk_sig, rst_sig, prop, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define RM2AA_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RM2AA_ASSERT(name, clk_sig, rst_sig, prop, msg)
`define RM2AA_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

@@ rtl/rm2aa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm2aa_pkg
// Shared widths, the queue entry type and the arctangent table.
// ----------------------------------------------------------------------------
package rm2aa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int N_ELEM    = 9;
  localparam int IN_DATA_W = 168;
  localparam int AXIS_W    = 18;
  localparam int ANGLE_W   = 19;
  localparam int OUT_DATA_W = 80;
  localparam int ONE       = 1 << FRAC_BITS;

  // queue entry fields
  localparam int RAD_W = 35;
  localparam int Q_W   = 19;
  localparam int V_W   = 20;

  // square root unit: one result bit per stage
  localparam int SQ_RAD_W  = 62;
  localparam int SQ_ROOT_W = 31;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;

  // divider: one quotient bit per stage
  localparam int DV_N_W = 36;
  localparam int DV_D_W = 20;
  localparam int DV_Q_W = 17;

  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_W     = 34;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef struct packed {
    logic                  trace_pos;
    logic [RAD_W-1:0]      rad;
    logic signed [Q_W-1:0] q;
    logic signed [V_W-1:0] v0;
    logic signed [V_W-1:0] v1;
    logic signed [V_W-1:0] v2;
  } item_t;

  // atan(2^-i) with 30 fractional bits
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd843314857;
      1:  r = 30'd497837829;
      2:  r = 30'd263043837;
      3:  r = 30'd133525159;
      4:  r = 30'd67021687;
      5:  r = 30'd33543516;
      6:  r = 30'd16775851;
      7:  r = 30'd8388437;
      8:  r = 30'd4194283;
      9:  r = 30'd2097149;
      10: r = 30'd1048576;
      11: r = 30'd524288;
      12: r = 30'd262144;
      13: r = 30'd131072;
      14: r = 30'd65536;
      15: r = 30'd32768;
      16: r = 30'd16384;
      17: r = 30'd8192;
      18: r = 30'd4096;
      19: r = 30'd2048;
      20: r = 30'd1024;
      21: r = 30'd512;
      22: r = 30'd256;
      23: r = 30'd128;
      24: r = 30'd64;
      25: r = 30'd32;
      26: r = 30'd16;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rm2aa_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm2aa_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rm2aa_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rm2aa_pkg::SQ_RAD_W-1:0]   rad,
  output logic [rm2aa_pkg::SQ_ROOT_W-1:0]  root
);
  import rm2aa_pkg::*;

  logic [SQ_REM_W-1:0]  rem_q  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_q [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rad_q  [SQ_ROOT_W];

  for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_stage
    logic [SQ_REM_W-1:0]  rem_in;
    logic [SQ_ROOT_W-1:0] root_in;
    logic [SQ_RAD_W-1:0]  rad_in;
    logic [SQ_REM_W+1:0]  cur;
    logic [SQ_REM_W+1:0]  trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign cur   = {rem_in, rad_in[SQ_RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_q[i]  <= SQ_REM_W'(cur - trial);
          root_q[i] <= {root_in[SQ_ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= cur[SQ_REM_W-1:0];
          root_q[i] <= {root_in[SQ_ROOT_W-2:0], 1'b0};
        end
        rad_q[i] <= {rad_in[SQ_RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQ_ROOT_W-1];

endmodule

@@ rtl/rm2aa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm2aa_div
// Pipelined restoring divider; quotient must fit its width.
// ----------------------------------------------------------------------------
module rm2aa_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rm2aa_pkg::DV_N_W-1:0]  num,
  input  logic [rm2aa_pkg::DV_D_W-1:0]  den,
  output logic [rm2aa_pkg::DV_Q_W-1:0]  quo
);
  import rm2aa_pkg::*;

  logic [DV_N_W-1:0] rem_q [DV_Q_W];
  logic [DV_D_W-1:0] den_q [DV_Q_W];
  logic [DV_Q_W-1:0] quo_q [DV_Q_W];

  for (genvar i = 0; i < DV_Q_W; i++) begin : g_stage
    localparam int B = DV_Q_W - 1 - i;
    logic [DV_N_W-1:0] rem_in;
    logic [DV_D_W-1:0] den_in;
    logic [DV_Q_W-1:0] quo_in;
    logic [DV_N_W-1:0] sh;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign sh = DV_N_W'(den_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= sh) begin
          rem_q[i] <= rem_in - sh;
          quo_q[i] <= {quo_in[DV_Q_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= {quo_in[DV_Q_W-2:0], 1'b0};
        end
        den_q[i] <= den_in;
      end
    end
  end

  assign quo = quo_q[DV_Q_W-1];

endmodule

@@ rtl/rm2aa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm2aa_front
// Unpacks a matrix, splits on the trace and the largest diagonal element.
// ----------------------------------------------------------------------------
module rm2aa_front (
  input  logic [rm2aa_pkg::IN_DATA_W-1:0] tdata,
  output rm2aa_pkg::item_t                item
);
  import rm2aa_pkg::*;

  logic signed [IN_W-1:0] m [N_ELEM];
  logic signed [V_W-1:0]  tr;
  logic signed [V_W-1:0]  tr1;
  logic signed [V_W:0]    d;
  logic [Q_W-1:0]         dpos;
  logic signed [V_W-1:0]  dv;
  logic                   sel0;
  logic                   sel1;

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      m[k] = tdata[k*IN_W +: IN_W];
    end
  end

  assign tr   = V_W'(m[0]) + V_W'(m[4]) + V_W'(m[8]);
  assign tr1  = tr + V_W'(ONE);
  assign sel0 = (m[0] > m[4]) && (m[0] > m[8]);
  assign sel1 = !sel0 && (m[4] > m[8]);

  always_comb begin
    if (sel0) begin
      d = (V_W+1)'(ONE) + (V_W+1)'(m[0]) - (V_W+1)'(m[4]) - (V_W+1)'(m[8]);
    end else if (sel1) begin
      d = (V_W+1)'(ONE) + (V_W+1)'(m[4]) - (V_W+1)'(m[0]) - (V_W+1)'(m[8]);
    end else begin
      d = (V_W+1)'(ONE) + (V_W+1)'(m[8]) - (V_W+1)'(m[0]) - (V_W+1)'(m[4]);
    end
  end

  assign dpos = d[V_W] ? '0 : d[Q_W-1:0];
  assign dv   = {1'b0, dpos};

  always_comb begin
    item.trace_pos = !tr[V_W-1];
    if (!tr[V_W-1]) begin
      item.rad = {2'b00, tr1[Q_W-1:0], 14'd0};
      item.q   = '0;
      item.v0  = V_W'(m[7]) - V_W'(m[5]);
      item.v1  = V_W'(m[2]) - V_W'(m[6]);
      item.v2  = V_W'(m[3]) - V_W'(m[1]);
    end else begin
      item.rad = {dpos, 16'd0};
      if (sel0) begin
        item.q  = Q_W'(m[7]) - Q_W'(m[5]);
        item.v0 = dv;
        item.v1 = V_W'(m[1]) + V_W'(m[3]);
        item.v2 = V_W'(m[2]) + V_W'(m[6]);
      end else if (sel1) begin
        item.q  = Q_W'(m[2]) - Q_W'(m[6]);
        item.v0 = V_W'(m[1]) + V_W'(m[3]);
        item.v1 = dv;
        item.v2 = V_W'(m[5]) + V_W'(m[7]);
      end else begin
        item.q  = Q_W'(m[3]) - Q_W'(m[1]);
        item.v0 = V_W'(m[2]) + V_W'(m[6]);
        item.v1 = V_W'(m[5]) + V_W'(m[7]);
        item.v2 = dv;
      end
    end
  end

endmodule

@@ rtl/rm2aa_queue.sv @@
`timescale 1ns / 1ps
`include "rotation_matrix_to_axis_angle_core_assert.svh"
// ----------------------------------------------------------------------------
// rm2aa_queue
// Short FIFO between the front classifier and the arithmetic back end.
// ----------------------------------------------------------------------------
module rm2aa_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rm2aa_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output rm2aa_pkg::item_t head
);
  import rm2aa_pkg::*;

  item_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign full       = (count == Q_CW'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  `RM2AA_ASSERT(a_count_bound, clk, rst, count <= Q_CW'(Q_DEPTH), "queue count above depth")
  `RM2AA_ASSERT(a_pop_nonempty, clk, rst, !(pop && count == '0), "pop from empty queue")
  `RM2AA_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count did not rise on push")

endmodule

@@ rtl/rm2aa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm2aa_back
// Cosine, arccosine and axis normalisation pipeline with output register.
// ----------------------------------------------------------------------------
module rm2aa_back (
  input  logic                                clk,
  input  logic                                rst,
  input  rm2aa_pkg::item_t                    head,
  input  logic                                head_valid,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rm2aa_pkg::AXIS_W-1:0] axis_x,
  output logic signed [rm2aa_pkg::AXIS_W-1:0] axis_y,
  output logic signed [rm2aa_pkg::AXIS_W-1:0] axis_z,
  output logic [rm2aa_pkg::ANGLE_W-1:0]       angle,
  output logic                                degenerate
);
  import rm2aa_pkg::*;

  localparam int POS_LAST = 2 * SQ_ROOT_W + DV_Q_W + CORDIC_ITERS + 5;
  localparam int AX_POS   = SQ_ROOT_W + DV_Q_W + 3;
  localparam int AX_DLY   = POS_LAST - AX_POS;
  localparam int MAG_W    = Q_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int C_W      = DV_Q_W;
  localparam int CSQ_W    = 2 * C_W;
  localparam int Z_W      = CORDIC_W + 2;
  localparam int A_W      = Z_W + 1;
  localparam int AXB_W    = 3 * AXIS_W + 1;
  localparam logic signed [Z_W-1:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [A_W-1:0] TWO_PI_Q30 = 37'sd6746518852;
  localparam logic signed [A_W-1:0] RND        = 37'sd8192;
  localparam logic signed [A_W-1:0] ANG_MAX    = 37'sd524287;

  logic en;
  logic [POS_LAST:0] vld;
  item_t p0;

  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[POS_LAST-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= head;
    end
  end

  // ---------------- cosine of the half angle ----------------
  logic [SQ_ROOT_W-1:0] root_a;
  logic [Q_W:0]         da [SQ_ROOT_W];

  rm2aa_sqrt u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .rad  ({{(SQ_RAD_W-RAD_W){1'b0}}, p0.rad}),
    .root (root_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      da[0] <= {p0.trace_pos, p0.q};
      for (int k = 1; k < SQ_ROOT_W; k++) begin
        da[k] <= da[k-1];
      end
    end
  end

  logic signed [Q_W-1:0] q31;
  logic [Q_W-1:0]        qmag;
  logic [IN_W-1:0]       s_val;
  logic [DV_N_W-1:0]     p1_num;
  logic [DV_D_W-1:0]     p1_den;
  logic                  p1_tp;
  logic                  p1_ovf;
  logic                  p1_qneg;
  logic [C_W-1:0]        p1_cost;

  assign q31   = da[SQ_ROOT_W-1][Q_W-1:0];
  assign qmag  = q31[Q_W-1] ? Q_W'(-q31) : q31;
  assign s_val = root_a[IN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num  <= {1'b0, qmag, 16'd0};
      p1_den  <= {1'b0, s_val, 1'b0};
      p1_tp   <= da[SQ_ROOT_W-1][Q_W];
      // quotient would not fit: cosine saturates (also covers a zero root)
      p1_ovf  <= ({1'b0, qmag} >= {s_val, 2'b00});
      p1_qneg <= q31[Q_W-1];
      p1_cost <= (root_a > SQ_ROOT_W'(ONE)) ? C_W'(ONE) : root_a[C_W-1:0];
    end
  end

  logic [DV_Q_W-1:0] quo_a;
  logic [C_W+2:0]    db [DV_Q_W];

  rm2aa_div u_div_a (
    .clk (clk),
    .en  (en),
    .num (p1_num),
    .den (p1_den),
    .quo (quo_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      db[0] <= {p1_tp, p1_ovf, p1_qneg, p1_cost};
      for (int k = 1; k < DV_Q_W; k++) begin
        db[k] <= db[k-1];
      end
    end
  end

  logic           tp49;
  logic           ovf49;
  logic           qneg49;
  logic [C_W-1:0] cost49;
  logic [C_W-1:0] cmag_n;
  logic [C_W-1:0] p2_cmag;
  logic           p2_cneg;

  assign {tp49, ovf49, qneg49, cost49} = db[DV_Q_W-1];

  always_comb begin
    if (tp49) begin
      cmag_n = cost49;
    end else if (ovf49 || quo_a > C_W'(ONE)) begin
      cmag_n = C_W'(ONE);
    end else begin
      cmag_n = quo_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_cmag <= cmag_n;
      // a zero cosine counts as non-negative
      p2_cneg <= !tp49 && qneg49 && (cmag_n != '0);
    end
  end

  // ---------------- arccosine ----------------
  logic [CSQ_W-1:0]     p3_csq;
  logic [C_W-1:0]       p3_cmag;
  logic                 p3_cneg;
  logic [SQ_RAD_W-1:0]  p4_rad;
  logic [SQ_ROOT_W-1:0] p4_m;
  logic                 p4_cneg;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_csq  <= p2_cmag * p2_cmag;
      p3_cmag <= p2_cmag;
      p3_cneg <= p2_cneg;
      // 2^60 - (c << 14)^2 = (2^32 - c^2) << 28
      p4_rad  <= {1'b0, (33'd1 << 32) - p3_csq[32:0], 28'd0};
      p4_m    <= {p3_cmag, 14'd0};
      p4_cneg <= p3_cneg;
    end
  end

  logic [SQ_ROOT_W-1:0] root_b;
  logic [SQ_ROOT_W:0]   dc [SQ_ROOT_W];

  rm2aa_sqrt u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .rad  (p4_rad),
    .root (root_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0] <= {p4_cneg, p4_m};
      for (int k = 1; k < SQ_ROOT_W; k++) begin
        dc[k] <= dc[k-1];
      end
    end
  end

  logic signed [CORDIC_W-1:0] cx [CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] cy [CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] cz [CORDIC_ITERS];
  logic                       dd [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    localparam logic signed [CORDIC_W-1:0] ATAN_I = $signed(CORDIC_W'(atan_q30(i)));
    logic signed [CORDIC_W-1:0] xi;
    logic signed [CORDIC_W-1:0] yi;
    logic signed [CORDIC_W-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, dc[SQ_ROOT_W-1][SQ_ROOT_W-1:0]});
      assign yi = $signed({3'b000, root_b});
      assign zi = '0;
    end else begin : g_next
      assign xi = cx[i-1];
      assign yi = cy[i-1];
      assign zi = cz[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          cx[i] <= xi + (yi >>> i);
          cy[i] <= yi - (xi >>> i);
          cz[i] <= zi + ATAN_I;
        end else begin
          cx[i] <= xi - (yi >>> i);
          cy[i] <= yi + (xi >>> i);
          cz[i] <= zi - ATAN_I;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= dc[SQ_ROOT_W-1][SQ_ROOT_W];
      for (int k = 1; k < CORDIC_ITERS; k++) begin
        dd[k] <= dd[k-1];
      end
    end
  end

  logic signed [CORDIC_W-1:0] zl;
  logic signed [Z_W-1:0]      zc;
  logic signed [Z_W-1:0]      p5_z;

  assign zl = cz[CORDIC_ITERS-1];
  assign zc = zl[CORDIC_W-1] ? '0 : Z_W'(zl);

  always_ff @(posedge clk) begin
    if (en) begin
      p5_z <= dd[CORDIC_ITERS-1] ? PI_Q30 - zc : zc;
    end
  end

  logic signed [A_W-1:0] ang2;
  logic signed [A_W-1:0] ang2c;
  logic signed [A_W-1:0] ang_r;
  logic signed [A_W-1:0] ang_s;

  assign ang2  = {p5_z, 1'b0};
  assign ang2c = (ang2 > TWO_PI_Q30) ? TWO_PI_Q30 : ang2;
  assign ang_r = (ang2c + RND) >>> (30 - FRAC_BITS);
  assign ang_s = (ang_r > ANG_MAX) ? ANG_MAX : ang_r;

  // ---------------- axis normalisation ----------------
  logic [MAG_W-1:0] mag1 [3];
  logic             neg1 [3];
  logic [SQ_W-1:0]  sq2  [3];
  logic [MAG_W-1:0] mag2 [3];
  logic             neg2 [3];
  logic             zero2;
  logic [SUM_W-1:0] sum3;
  logic [MAG_W-1:0] mag3 [3];
  logic             neg3 [3];
  logic             zero3;
  logic signed [V_W-1:0] vin [3];

  assign vin[0] = p0.v0;
  assign vin[1] = p0.v1;
  assign vin[2] = p0.v2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag1[k] <= vin[k][V_W-1] ? MAG_W'(-vin[k]) : vin[k][MAG_W-1:0];
        neg1[k] <= vin[k][V_W-1];
        sq2[k]  <= mag1[k] * mag1[k];
        mag2[k] <= mag1[k];
        neg2[k] <= neg1[k];
        mag3[k] <= mag2[k];
        neg3[k] <= neg2[k];
      end
      zero2 <= (mag1[0] == '0) && (mag1[1] == '0) && (mag1[2] == '0);
      sum3  <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      zero3 <= zero2;
    end
  end

  logic [SQ_ROOT_W-1:0] len;
  logic [3*MAG_W+3:0]   de [SQ_ROOT_W];

  rm2aa_sqrt u_sqrt_c (
    .clk  (clk),
    .en   (en),
    .rad  ({{(SQ_RAD_W-SUM_W){1'b0}}, sum3}),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      de[0] <= {zero3, neg3[2], neg3[1], neg3[0], mag3[2], mag3[1], mag3[0]};
      for (int k = 1; k < SQ_ROOT_W; k++) begin
        de[k] <= de[k-1];
      end
    end
  end

  logic [DV_Q_W-1:0] quo_v [3];
  logic [3:0]        df [DV_Q_W];

  for (genvar j = 0; j < 3; j++) begin : g_ndiv
    rm2aa_div u_div_v (
      .clk (clk),
      .en  (en),
      .num ({1'b0, de[SQ_ROOT_W-1][j*MAG_W +: MAG_W], 16'd0}),
      .den (len[DV_D_W-1:0]),
      .quo (quo_v[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      df[0] <= de[SQ_ROOT_W-1][3*MAG_W +: 4];
      for (int k = 1; k < DV_Q_W; k++) begin
        df[k] <= df[k-1];
      end
    end
  end

  logic signed [AXIS_W-1:0] ax_n [3];
  logic [AXB_W-1:0]         dg [AX_DLY];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (df[DV_Q_W-1][3]) begin
        ax_n[k] = (k == 0) ? AXIS_W'(ONE) : '0;
      end else if (df[DV_Q_W-1][k]) begin
        ax_n[k] = -$signed({1'b0, quo_v[k]});
      end else begin
        ax_n[k] = $signed({1'b0, quo_v[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= {df[DV_Q_W-1][3], ax_n[2], ax_n[1], ax_n[0]};
      for (int k = 1; k < AX_DLY; k++) begin
        dg[k] <= dg[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[POS_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis_x     <= dg[AX_DLY-1][AXIS_W-1:0];
      axis_y     <= dg[AX_DLY-1][2*AXIS_W-1:AXIS_W];
      axis_z     <= dg[AX_DLY-1][3*AXIS_W-1:2*AXIS_W];
      degenerate <= dg[AX_DLY-1][3*AXIS_W];
      angle      <= ang_s[ANGLE_W-1:0];
    end
  end

endmodule

@@ rtl/rotation_matrix_to_axis_angle_core.sv @@
`timescale 1ns / 1ps
// Throughput: one matrix per cycle while the output side accepts results; the
// pipelined square roots (31 stages each), dividers (17) and CORDIC (30) set
// the latency. The back end stalls as a whole while the output register holds
// a result. Reset (rst, synchronous) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
// rotation_matrix_to_axis_angle_core
// Converts a Q2.16 rotation matrix to a unit axis and an angle in radians.
// ----------------------------------------------------------------------------
module rotation_matrix_to_axis_angle_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (18 bits each)
  input  logic [rm2aa_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // axis_x, axis_y, axis_z (18 bits each), angle (19 bits)
  output logic [rm2aa_pkg::OUT_DATA_W-1:0]    m_tdata,
  // degenerate
  output logic [0:0]                          m_tuser
);
  import rm2aa_pkg::*;

  item_t                    front_item;
  item_t                    head;
  logic                     full;
  logic                     head_valid;
  logic                     pop;
  logic                     push;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;
  logic [ANGLE_W-1:0]       angle;
  logic                     degenerate;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  rm2aa_front u_front (
    .tdata (s_tdata),
    .item  (front_item)
  );

  rm2aa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rm2aa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z),
    .angle      (angle),
    .degenerate (degenerate)
  );

  assign m_tdata = {7'd0, angle, axis_z, axis_y, axis_x};
  assign m_tuser = degenerate;

endmodule
